/* src/lavm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;

  // unit vector component: magnitude at most one
  localparam int QW = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;

  // widest vector handed to the normalizer (up cross z)
  localparam int PUW = DW + UW;
  localparam int VW = PUW + 1;
  localparam int ZPW = 2 * UW;
  localparam int DOTW = PUW + 2;

  // normalizer internals
  localparam int NSH = $clog2(VW);
  localparam int NRM = 30;
  localparam int SW = 2 * NRM + 2;
  localparam int SQ = NRM + 1;
  localparam int NUMW = NRM + FRAC_BITS + 1;
  localparam int UNIT_LAT = 3 + NSH + SQ + QW;

  // fixed near-y fallback vectors
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam longint WV_FB_X_L = (ONE_L * 5 + 50000) / 100000;
  localparam longint WV_FB_Y_L = ONE_L + (ONE_L * 1 + 50000) / 100000;
  localparam longint VW_FB_X_L = (ONE_L * 15 + 50000) / 100000;
  localparam longint VW_FB_Y_L = ONE_L + (ONE_L * 21 + 50000) / 100000;
  localparam logic signed [UW-1:0] WV_FB_X = UW'(WV_FB_X_L);
  localparam logic signed [UW-1:0] WV_FB_Y = UW'(WV_FB_Y_L);
  localparam logic signed [UW-1:0] VW_FB_X = UW'(VW_FB_X_L);
  localparam logic signed [UW-1:0] VW_FB_Y = UW'(VW_FB_Y_L);

  localparam logic [DW-1:0] UP_Z_RST = DW'(1) << FRAC_BITS;

  // register map
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  localparam logic OP_WORLD_TO_VIEW = 1'b0;
  localparam logic OP_VIEW_TO_WORLD = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic signed [DW-1:0]  eye_x;
    logic signed [DW-1:0]  eye_y;
    logic signed [DW-1:0]  eye_z;
    logic signed [DW-1:0]  target_x;
    logic signed [DW-1:0]  target_y;
    logic signed [DW-1:0]  target_z;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] m_r0_c0;
    logic signed [DW-1:0] m_r0_c1;
    logic signed [DW-1:0] m_r0_c2;
    logic signed [DW-1:0] m_r0_c3;
    logic signed [DW-1:0] m_r1_c0;
    logic signed [DW-1:0] m_r1_c1;
    logic signed [DW-1:0] m_r1_c2;
    logic signed [DW-1:0] m_r1_c3;
    logic signed [DW-1:0] m_r2_c0;
    logic signed [DW-1:0] m_r2_c1;
    logic signed [DW-1:0] m_r2_c2;
    logic signed [DW-1:0] m_r2_c3;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } unit_stat_t;

  typedef struct packed {
    logic                  op;
    logic                  ok;
    logic [2:0][DW-1:0]    e;
    logic [2:0][UW-1:0]    z;
    logic [2:0][UW-1:0]    x;
    logic [2:0][UW-1:0]    y;
  } side_t;

endpackage
`default_nettype wire

/* src/lavm_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module lavm_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                vld,
  input  logic [2:0][lavm_pkg::VW-1:0]        v,
  output lavm_pkg::unit_stat_t                stat,
  output logic [2:0][lavm_pkg::UW-1:0]        u
);

  localparam int MW = lavm_pkg::VW;
  localparam int NSH = lavm_pkg::NSH;
  localparam int NRM = lavm_pkg::NRM;
  localparam int SW = lavm_pkg::SW;
  localparam int SQ = lavm_pkg::SQ;
  localparam int QW = lavm_pkg::QW;
  localparam int UW = lavm_pkg::UW;
  localparam int NUMW = lavm_pkg::NUMW;
  localparam int FB = lavm_pkg::FRAC_BITS;

  // magnitude and left normalize
  logic               nm_v  [NSH+1];
  logic               nm_nz [NSH+1];
  logic [2:0]         nm_sg [NSH+1];
  logic [2:0][MW-1:0] nm_m  [NSH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_v[0] <= 1'b0;
    end else if (adv) begin
      nm_v[0] <= vld;
    end
    if (adv) begin
      nm_nz[0] <= |v;
      for (int i = 0; i < 3; i++) begin
        nm_sg[0][i] <= v[i][MW-1];
        nm_m[0][i] <= v[i][MW-1] ? (~v[i] + 1'b1) : v[i];
      end
    end
  end

  for (genvar k = 0; k < NSH; k++) begin : g_nrm
    localparam int SH = 1 << (NSH - 1 - k);
    logic [MW-1:0] orv;
    logic          hz;
    assign orv = nm_m[k][0] | nm_m[k][1] | nm_m[k][2];
    assign hz = ~|orv[MW-1 -: SH];
    always_ff @(posedge clk) begin
      if (rst) begin
        nm_v[k+1] <= 1'b0;
      end else if (adv) begin
        nm_v[k+1] <= nm_v[k];
      end
      if (adv) begin
        nm_nz[k+1] <= nm_nz[k];
        nm_sg[k+1] <= nm_sg[k];
        for (int i = 0; i < 3; i++) begin
          nm_m[k+1][i] <= hz ? (nm_m[k][i] << SH) : nm_m[k][i];
        end
      end
    end
  end

  // truncate to the top bits and square
  logic                  sq_v, sq_nz;
  logic [2:0]            sq_sg;
  logic [2:0][NRM-1:0]   sq_mn;
  logic [2:0][2*NRM-1:0] sq_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (adv) begin
      sq_v <= nm_v[NSH];
    end
    if (adv) begin
      sq_nz <= nm_nz[NSH];
      sq_sg <= nm_sg[NSH];
      for (int i = 0; i < 3; i++) begin
        sq_mn[i] <= nm_m[NSH][i][MW-1 -: NRM];
        sq_p[i] <= nm_m[NSH][i][MW-1 -: NRM] * nm_m[NSH][i][MW-1 -: NRM];
      end
    end
  end

  // sum of squares
  logic                sm_v, sm_nz;
  logic [2:0]          sm_sg;
  logic [2:0][NRM-1:0] sm_mn;
  logic [SW-1:0]       sm_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_v <= 1'b0;
    end else if (adv) begin
      sm_v <= sq_v;
    end
    if (adv) begin
      sm_nz <= sq_nz;
      sm_sg <= sq_sg;
      sm_mn <= sq_mn;
      sm_s <= SW'(sq_p[0]) + SW'(sq_p[1]) + SW'(sq_p[2]);
    end
  end

  // square root, one result bit per stage
  logic                rt_v  [SQ];
  logic                rt_nz [SQ];
  logic [2:0]          rt_sg [SQ];
  logic [2:0][NRM-1:0] rt_mn [SQ];
  logic [SW-1:0]       rt_s  [SQ];
  logic [SW-1:0]       rt_r  [SQ];

  for (genvar t = 0; t < SQ; t++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ - 1 - t));
    logic [SW-1:0]       si, ri, tr;
    logic [2:0][NRM-1:0] mi;
    logic [2:0]          gi;
    logic                zi, vi;
    if (t == 0) begin : g_first
      assign si = sm_s;
      assign ri = '0;
      assign mi = sm_mn;
      assign gi = sm_sg;
      assign zi = sm_nz;
      assign vi = sm_v;
    end else begin : g_next
      assign si = rt_s[t-1];
      assign ri = rt_r[t-1];
      assign mi = rt_mn[t-1];
      assign gi = rt_sg[t-1];
      assign zi = rt_nz[t-1];
      assign vi = rt_v[t-1];
    end
    assign tr = ri + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[t] <= 1'b0;
      end else if (adv) begin
        rt_v[t] <= vi;
      end
      if (adv) begin
        rt_nz[t] <= zi;
        rt_sg[t] <= gi;
        rt_mn[t] <= mi;
        if (si >= tr) begin
          rt_s[t] <= si - tr;
          rt_r[t] <= (ri >> 1) + BIT;
        end else begin
          rt_s[t] <= si;
          rt_r[t] <= ri >> 1;
        end
      end
    end
  end

  // rounded division of each magnitude by the norm, one quotient bit per stage
  logic                 dv_v   [QW];
  logic                 dv_nz  [QW];
  logic [2:0]           dv_sg  [QW];
  logic [SQ-1:0]        dv_n   [QW];
  logic [2:0][NUMW-1:0] dv_rem [QW];
  logic [2:0][QW-1:0]   dv_q   [QW];

  logic [SQ-1:0] n0;
  assign n0 = rt_r[SQ-1][SQ-1:0];

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int J = QW - 1 - t;
    logic [2:0][NUMW-1:0] ri;
    logic [2:0][QW-1:0]   qi;
    logic [SQ-1:0]        ni;
    logic [2:0]           gi;
    logic                 zi, vi;
    logic [NUMW-1:0]      dsh;
    if (t == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign ri[i] = (NUMW'(rt_mn[SQ-1][i]) << FB) + NUMW'(n0 >> 1);
      end
      assign qi = '0;
      assign ni = n0;
      assign gi = rt_sg[SQ-1];
      assign zi = rt_nz[SQ-1];
      assign vi = rt_v[SQ-1];
    end else begin : g_next
      assign ri = dv_rem[t-1];
      assign qi = dv_q[t-1];
      assign ni = dv_n[t-1];
      assign gi = dv_sg[t-1];
      assign zi = dv_nz[t-1];
      assign vi = dv_v[t-1];
    end
    assign dsh = NUMW'(ni) << J;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[t] <= 1'b0;
      end else if (adv) begin
        dv_v[t] <= vi;
      end
      if (adv) begin
        dv_nz[t] <= zi;
        dv_sg[t] <= gi;
        dv_n[t] <= ni;
        for (int i = 0; i < 3; i++) begin
          if (ri[i] >= dsh) begin
            dv_rem[t][i] <= ri[i] - dsh;
            dv_q[t][i] <= qi[i] | (QW'(1) << J);
          end else begin
            dv_rem[t][i] <= ri[i];
            dv_q[t][i] <= qi[i];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_nz[QW-1]) begin
        u[i] = '0;
      end else if (dv_sg[QW-1][i]) begin
        u[i] = UW'(0) - UW'(dv_q[QW-1][i]);
      end else begin
        u[i] = UW'(dv_q[QW-1][i]);
      end
    end
  end

  assign stat.valid = dv_v[QW-1];
  assign stat.ok = dv_nz[QW-1];

endmodule
`default_nettype wire

/* src/look_at_view_matrix_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// look-at camera matrix: builds z = unit(eye - target), x = unit(up cross z),
// y = unit(z cross x) in signed q16.16 and returns one 3x4 matrix per transfer,
// either [x y z eye] as columns (view-to-world) or the rigid inverse with rows
// x, y, z and translation -(row . eye), rounded and saturated (world-to-view).
// if up is parallel to z a fixed near-y vector stands in for up; a degenerate
// eye or axis gives an all-zero matrix. the up vector sits in three apb
// registers (0x0 up_x, 0x4 up_y, 0x8 up_z, reset 0, 0, one), which the user
// sees are written only while no transfer is in flight; the block does not
// enforce it. the datapath is a single stall-together pipeline: one item is
// taken every clock while the output is not stalled, and a result passes
// stage a, the z, x and y normalizers with stages b, c and d, e between them,
// then stages f, g and the output register. each normalizer has an input
// stage, 6 normalize shifts, square, sum, 31 square-root and 17 divide stages.
module look_at_view_matrix_top (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            item_valid,
  output logic                            item_ready,
  input  lavm_pkg::item_t                 item,
  // results
  output logic                            result_valid,
  input  logic                            result_ready,
  output lavm_pkg::result_t               result,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lavm_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int DW = lavm_pkg::DW;
  localparam int UW = lavm_pkg::UW;
  localparam int VW = lavm_pkg::VW;
  localparam int PUW = lavm_pkg::PUW;
  localparam int ZPW = lavm_pkg::ZPW;
  localparam int DOTW = lavm_pkg::DOTW;
  localparam int L = lavm_pkg::UNIT_LAT;
  localparam int FB = lavm_pkg::FRAC_BITS;
  localparam logic [DOTW-1:0] HALF = DOTW'(1) << (FB - 1);
  localparam logic [DOTW-1:0] SAT_POS = DOTW'(2147483647);
  localparam logic [DOTW-1:0] SAT_NEG = DOTW'(1) << (DW - 1);

  // whole pipeline moves together when the output stage can take a transfer
  logic adv;
  assign adv = !result_valid || result_ready;
  assign item_ready = adv;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] up_x, up_y, up_z;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= '0;
      up_y <= '0;
      up_z <= lavm_pkg::UP_Z_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        lavm_pkg::REG_UP_X: up_x <= pwdata;
        lavm_pkg::REG_UP_Y: up_y <= pwdata;
        lavm_pkg::REG_UP_Z: up_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lavm_pkg::REG_UP_X: prdata = up_x;
      lavm_pkg::REG_UP_Y: prdata = up_y;
      lavm_pkg::REG_UP_Z: prdata = up_z;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // stage a: capture, form eye - target
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] eye [3];
  logic signed [DW-1:0] tgt [3];
  assign eye[0] = item.eye_x;
  assign eye[1] = item.eye_y;
  assign eye[2] = item.eye_z;
  assign tgt[0] = item.target_x;
  assign tgt[1] = item.target_y;
  assign tgt[2] = item.target_z;

  logic                 a_vld;
  lavm_pkg::side_t      a_side;
  logic [2:0][VW-1:0]   a_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= item_valid;
    end
    if (adv) begin
      a_side.op <= item.operation;
      a_side.ok <= 1'b1;
      a_side.z <= '0;
      a_side.x <= '0;
      a_side.y <= '0;
      for (int i = 0; i < 3; i++) begin
        a_side.e[i] <= eye[i];
        a_v[i] <= VW'(eye[i]) - VW'(tgt[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // z axis
  // ---------------------------------------------------------------------------
  lavm_pkg::unit_stat_t zst;
  logic [2:0][UW-1:0]   uz;
  lavm_pkg::side_t      dz [L];

  lavm_unit u_unit_z (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .vld  (a_vld),
    .v    (a_v),
    .stat (zst),
    .u    (uz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dz[0] <= a_side;
      for (int k = 1; k < L; k++) begin
        dz[k] <= dz[k-1];
      end
    end
  end

  // stage b: up cross z and fallback cross z products
  logic signed [UW-1:0] zs [3];
  logic signed [UW-1:0] fbx, fby;
  assign zs[0] = uz[0];
  assign zs[1] = uz[1];
  assign zs[2] = uz[2];
  assign fbx = (dz[L-1].op == lavm_pkg::OP_VIEW_TO_WORLD) ? lavm_pkg::VW_FB_X
                                                          : lavm_pkg::WV_FB_X;
  assign fby = (dz[L-1].op == lavm_pkg::OP_VIEW_TO_WORLD) ? lavm_pkg::VW_FB_Y
                                                          : lavm_pkg::WV_FB_Y;

  logic                  b_vld;
  lavm_pkg::side_t       b_side;
  logic signed [PUW-1:0] b_pu [6];
  logic signed [PUW-1:0] b_pf [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= zst.valid;
    end
    if (adv) begin
      b_side.op <= dz[L-1].op;
      b_side.ok <= dz[L-1].ok & zst.ok;
      b_side.e <= dz[L-1].e;
      b_side.z <= uz;
      b_side.x <= dz[L-1].x;
      b_side.y <= dz[L-1].y;
      b_pu[0] <= PUW'(up_y) * PUW'(zs[2]);
      b_pu[1] <= PUW'(up_z) * PUW'(zs[1]);
      b_pu[2] <= PUW'(up_z) * PUW'(zs[0]);
      b_pu[3] <= PUW'(up_x) * PUW'(zs[2]);
      b_pu[4] <= PUW'(up_x) * PUW'(zs[1]);
      b_pu[5] <= PUW'(up_y) * PUW'(zs[0]);
      b_pf[0] <= PUW'(fby) * PUW'(zs[2]);
      b_pf[1] <= PUW'(fbx) * PUW'(zs[2]);
      b_pf[2] <= PUW'(fbx) * PUW'(zs[1]);
      b_pf[3] <= PUW'(fby) * PUW'(zs[0]);
    end
  end

  // stage c: differences, fall back when up is parallel to z
  logic [VW-1:0] cu [3];
  logic [VW-1:0] cf [3];
  logic          c_zero;
  assign cu[0] = VW'(b_pu[0]) - VW'(b_pu[1]);
  assign cu[1] = VW'(b_pu[2]) - VW'(b_pu[3]);
  assign cu[2] = VW'(b_pu[4]) - VW'(b_pu[5]);
  assign cf[0] = VW'(b_pf[0]);
  assign cf[1] = VW'(0) - VW'(b_pf[1]);
  assign cf[2] = VW'(b_pf[2]) - VW'(b_pf[3]);
  assign c_zero = (cu[0] == '0) && (cu[1] == '0) && (cu[2] == '0);

  logic               c_vld;
  lavm_pkg::side_t    c_side;
  logic [2:0][VW-1:0] c_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
    if (adv) begin
      c_side <= b_side;
      for (int i = 0; i < 3; i++) begin
        c_v[i] <= c_zero ? cf[i] : cu[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // x axis
  // ---------------------------------------------------------------------------
  lavm_pkg::unit_stat_t xst;
  logic [2:0][UW-1:0]   ux;
  lavm_pkg::side_t      dx [L];

  lavm_unit u_unit_x (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .vld  (c_vld),
    .v    (c_v),
    .stat (xst),
    .u    (ux)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dx[0] <= c_side;
      for (int k = 1; k < L; k++) begin
        dx[k] <= dx[k-1];
      end
    end
  end

  // stage d: z cross x products
  logic signed [UW-1:0] z2s [3];
  logic signed [UW-1:0] xs [3];
  for (genvar i = 0; i < 3; i++) begin : g_zx
    assign z2s[i] = dx[L-1].z[i];
    assign xs[i] = ux[i];
  end

  logic                  d_vld;
  lavm_pkg::side_t       d_side;
  logic signed [ZPW-1:0] d_p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= xst.valid;
    end
    if (adv) begin
      d_side.op <= dx[L-1].op;
      d_side.ok <= dx[L-1].ok & xst.ok;
      d_side.e <= dx[L-1].e;
      d_side.z <= dx[L-1].z;
      d_side.x <= ux;
      d_side.y <= dx[L-1].y;
      d_p[0] <= ZPW'(z2s[1]) * ZPW'(xs[2]);
      d_p[1] <= ZPW'(z2s[2]) * ZPW'(xs[1]);
      d_p[2] <= ZPW'(z2s[2]) * ZPW'(xs[0]);
      d_p[3] <= ZPW'(z2s[0]) * ZPW'(xs[2]);
      d_p[4] <= ZPW'(z2s[0]) * ZPW'(xs[1]);
      d_p[5] <= ZPW'(z2s[1]) * ZPW'(xs[0]);
    end
  end

  // stage e: differences
  logic               e_vld;
  lavm_pkg::side_t    e_side;
  logic [2:0][VW-1:0] e_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
    if (adv) begin
      e_side <= d_side;
      e_v[0] <= VW'(d_p[0]) - VW'(d_p[1]);
      e_v[1] <= VW'(d_p[2]) - VW'(d_p[3]);
      e_v[2] <= VW'(d_p[4]) - VW'(d_p[5]);
    end
  end

  // ---------------------------------------------------------------------------
  // y axis
  // ---------------------------------------------------------------------------
  lavm_pkg::unit_stat_t yst;
  logic [2:0][UW-1:0]   uy;
  lavm_pkg::side_t      dy [L];

  lavm_unit u_unit_y (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .vld  (e_vld),
    .v    (e_v),
    .stat (yst),
    .u    (uy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dy[0] <= e_side;
      for (int k = 1; k < L; k++) begin
        dy[k] <= dy[k-1];
      end
    end
  end

  // stage f: row . eye products for the translation
  logic [2:0][2:0][UW-1:0] rw;
  assign rw[0] = dy[L-1].x;
  assign rw[1] = uy;
  assign rw[2] = dy[L-1].z;

  logic                  f_vld;
  lavm_pkg::side_t       f_side;
  logic [2:0][2:0][PUW-1:0] f_dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= yst.valid;
    end
    if (adv) begin
      f_side.op <= dy[L-1].op;
      f_side.ok <= dy[L-1].ok & yst.ok;
      f_side.e <= dy[L-1].e;
      f_side.z <= dy[L-1].z;
      f_side.x <= dy[L-1].x;
      f_side.y <= uy;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          f_dp[i][j] <= PUW'($signed(rw[i][j])) * PUW'($signed(dy[L-1].e[j]));
        end
      end
    end
  end

  // stage g: dot sums
  logic                      g_vld;
  lavm_pkg::side_t           g_side;
  logic [2:0][DOTW-1:0]      g_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= f_vld;
    end
    if (adv) begin
      g_side <= f_side;
      for (int i = 0; i < 3; i++) begin
        g_dot[i] <= DOTW'($signed(f_dp[i][0])) + DOTW'($signed(f_dp[i][1]))
                  + DOTW'($signed(f_dp[i][2]));
      end
    end
  end

  // stage h: round, negate, saturate, assemble the matrix
  logic [2:0][DOTW-1:0] am, rm;
  logic [2:0][DW-1:0]   trans;
  logic [0:11][DW-1:0]  mv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      am[i] = g_dot[i][DOTW-1] ? (~g_dot[i] + 1'b1) : g_dot[i];
      rm[i] = (am[i] + HALF) >> FB;
      if (g_dot[i][DOTW-1]) begin
        // negative dot gives a positive translation
        trans[i] = (rm[i] > SAT_POS) ? DW'(SAT_POS) : rm[i][DW-1:0];
      end else begin
        trans[i] = (rm[i] > SAT_NEG) ? DW'(SAT_NEG) : (DW'(0) - rm[i][DW-1:0]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (g_side.op == lavm_pkg::OP_VIEW_TO_WORLD) begin
        mv[4*i]   = DW'($signed(g_side.x[i]));
        mv[4*i+1] = DW'($signed(g_side.y[i]));
        mv[4*i+2] = DW'($signed(g_side.z[i]));
        mv[4*i+3] = g_side.e[i];
      end else begin
        for (int j = 0; j < 3; j++) begin
          case (i)
            0:       mv[4*i+j] = DW'($signed(g_side.x[j]));
            1:       mv[4*i+j] = DW'($signed(g_side.y[j]));
            default: mv[4*i+j] = DW'($signed(g_side.z[j]));
          endcase
        end
        mv[4*i+3] = trans[i];
      end
    end
    if (!g_side.ok) begin
      mv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= g_vld;
    end
    if (adv) begin
      result <= lavm_pkg::result_t'(mv);
    end
  end

endmodule
`default_nettype wire
